@@ rtl/bte_pkg.sv @@
// ----------------------------------------------------------------------------
// bte_pkg: shared types and constants of the battery time-left estimator
// Command and status bundles between controller and datapath, direction
// codes, register indexes and register reset values.
// ----------------------------------------------------------------------------
package bte_pkg;

  localparam logic [1:0] DIR_DISCHARGE = 2'd0;
  localparam logic [1:0] DIR_CHARGE    = 2'd1;
  localparam logic [1:0] DIR_NONE      = 2'd2;
  localparam logic [1:0] DIR_ALIAS     = 2'd3;

  localparam logic REG_FULL_CHARGE = 1'b0;
  localparam logic REG_MIN_WINDOW  = 1'b1;

  localparam logic [23:0] FULL_CHARGE_RESET = 24'hFF_FFFF;
  localparam logic [15:0] MIN_WINDOW_RESET  = 16'd60;
  localparam logic [31:0] NO_ESTIMATE       = 32'hFFFF_FFFF;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_FIRST,
    OP_PREP,
    OP_NEWDIR,
    OP_OPEN,
    OP_ACC,
    OP_CSWEEP,
    OP_CCLR,
    OP_EST,
    OP_DIV,
    OP_RES
  } dp_op_e;

  typedef enum logic [1:0] {
    SW_UNBIASED,
    SW_CLEAR,
    SW_ESTIMATE
  } sw_mode_e;

  typedef struct packed {
    dp_op_e op;
  } cmd_t;

  typedef struct packed {
    logic started;
    logic close_needed;
    logic dir_none;
    logic reading_diff;
    logic open_now;
    logic dur_ge_min;
    logic cons_filled;
    logic tot_ge_min;
    logic count_nz;
    logic tp_nz;
    logic sweep_busy;
    logic div_busy;
    logic out_free;
  } status_t;

endpackage

@@ rtl/bte_muldiv.sv @@
// ----------------------------------------------------------------------------
// bte_muldiv: serial multiply and divide unit
// Forms |rem| * tt by shift-and-add, one bit a cycle, then divides by tp by
// restoring division, one quotient bit a cycle; applies sign and saturation.
// ----------------------------------------------------------------------------
module bte_muldiv #(
  parameter int unsigned TW = 37
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [23:0]   mag_i,
  input  logic          neg_i,
  input  logic [TW-1:0] tt_i,
  input  logic [TW-1:0] tp_i,
  output logic          busy_o,
  output logic [31:0]   result_o
);

  localparam int unsigned NW   = 24 + TW;
  localparam int unsigned CNTW = $clog2(NW + 1);

  logic            busy_q, div_ph_q, neg_q;
  logic [CNTW-1:0] cnt_q;
  logic [23:0]     mag_q;
  logic [NW-1:0]   tsh_q, nq_q;
  logic [TW-1:0]   r_q, tp_q;
  logic [31:0]     res_q;

  logic [TW:0]   r_sh, r_diff;
  logic          ge;
  logic [NW-1:0] q_fin;
  logic [31:0]   sat;

  always_comb begin
    r_sh   = {r_q, nq_q[NW-1]};
    r_diff = r_sh - {1'b0, tp_q};
    ge     = (r_sh >= {1'b0, tp_q});
    q_fin  = {nq_q[NW-2:0], ge};
    if (!neg_q) begin
      sat = (q_fin > NW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q_fin[31:0];
    end else begin
      sat = (q_fin > NW'(33'h0_8000_0000)) ? 32'h8000_0000 : (32'd0 - q_fin[31:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      div_ph_q <= 1'b0;
      cnt_q    <= '0;
    end else if (start_i) begin
      busy_q   <= 1'b1;
      div_ph_q <= 1'b0;
      cnt_q    <= CNTW'(24);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNTW'(1);
      if (cnt_q == CNTW'(1)) begin
        if (!div_ph_q) begin
          div_ph_q <= 1'b1;
          cnt_q    <= CNTW'(NW);
        end else begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q <= mag_i;
      tsh_q <= NW'(tt_i);
      nq_q  <= '0;
      tp_q  <= tp_i;
      neg_q <= neg_i;
      r_q   <= '0;
    end else if (busy_q && !div_ph_q) begin
      if (mag_q[0]) begin
        nq_q <= nq_q + tsh_q;
      end
      mag_q <= mag_q >> 1;
      tsh_q <= tsh_q << 1;
    end else if (busy_q) begin
      r_q  <= ge ? r_diff[TW-1:0] : r_sh[TW-1:0];
      nq_q <= q_fin;
      if (cnt_q == CNTW'(1)) begin
        res_q <= sat;
      end
    end
  end

  assign busy_o   = busy_q;
  assign result_o = res_q;

endmodule

@@ rtl/bte_datapath.sv @@
// ----------------------------------------------------------------------------
// bte_datapath: slot store, bank state and arithmetic of the estimator
// Executes one controller command a cycle; sweeps a bank through the slot
// memory one slot a cycle and hands the sums to the multiply/divide unit.
// ----------------------------------------------------------------------------
module bte_datapath #(
  parameter int unsigned SLOTS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bte_pkg::cmd_t    cmd_i,
  output bte_pkg::status_t status_o,
  input  logic [23:0]      in_reading_i,
  input  logic [1:0]       in_dir_i,
  input  logic [31:0]      in_time_i,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [23:0]      cfg_data_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic [31:0]      out_seconds_o,
  output logic             out_has_o
);

  localparam int unsigned IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW    = $clog2(SLOTS + 1);
  localparam int unsigned DEPTH = 2 * SLOTS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned TW    = 32 + CW;

  function automatic logic [AW-1:0] slot_addr(input logic bank, input logic [IW-1:0] idx);
    slot_addr = bank ? (AW'(SLOTS) + AW'(idx)) : AW'(idx);
  endfunction

  // configuration
  logic [23:0] full_q;
  logic [15:0] min_q;

  // item and bank state
  logic [23:0]   reading_q, last_reading_q;
  logic [1:0]    dir_q, prev_q, last_dir_q;
  logic [31:0]   now_q, window_q;
  logic          started_q, opened_q, cons_bank_q, has_q;
  logic [1:0]    ov_q, bp_q, uf_q;
  logic [IW-1:0] open_slot_q [2];
  logic [CW-1:0] count_q [2];

  // sweep
  logic              sw_active_q, sw_vld_q, sw_bank_q;
  bte_pkg::sw_mode_e sw_mode_q;
  logic [CW-1:0]     sw_idx_q;
  logic [AW-1:0]     sw_addr_q;
  logic [TW-1:0]     tot_q, tp_q, tt_q;

  // slot memory
  logic [31:0] mem_chg [DEPTH];
  logic [31:0] mem_dur [DEPTH];
  logic        mem_bias [DEPTH];
  logic [31:0] chg_rd_q, dur_rd_q;
  logic        bias_rd_q;

  // result
  logic        out_valid_q, out_has_q;
  logic [31:0] out_seconds_q;

  logic          cur_b, prev_b, opening, close_needed;
  logic [IW-1:0] alloc_idx;
  logic [31:0]   dur_now, chg_new, abs_chg;
  logic [AW-1:0] rd_addr, wr_addr, open_addr;
  logic          we_chg, we_dur, we_bias, wr_bias;
  logic [31:0]   wr_chg, wr_dur;
  logic          sw_start;
  logic          sw_start_bank;
  bte_pkg::sw_mode_e sw_start_mode;
  logic [24:0]   rem;
  logic          div_busy;
  logic [31:0]   div_res;

  assign cur_b        = dir_q[0];
  assign prev_b       = prev_q[0];
  assign close_needed = (prev_q != dir_q) && (prev_q != bte_pkg::DIR_NONE) && ov_q[prev_b];
  assign opening      = !ov_q[cur_b] && !(bp_q[cur_b] && uf_q[cur_b]);
  assign alloc_idx    = (count_q[cur_b] < CW'(SLOTS)) ? count_q[cur_b][IW-1:0] : '0;
  assign dur_now      = now_q - window_q;
  assign open_addr    = slot_addr(cur_b, open_slot_q[cur_b]);
  assign chg_new      = (opened_q ? 32'd0 : chg_rd_q) + ({8'd0, reading_q} - {8'd0, last_reading_q});
  assign abs_chg      = chg_rd_q[31] ? (32'd0 - chg_rd_q) : chg_rd_q;
  assign rem          = dir_q[0] ? ({1'b0, full_q} - {1'b0, reading_q}) : {1'b0, reading_q};

  // command decode: memory ports and sweep starts
  always_comb begin
    rd_addr       = slot_addr(sw_bank_q, sw_idx_q[IW-1:0]);
    wr_addr       = sw_addr_q;
    we_chg        = 1'b0;
    we_dur        = 1'b0;
    we_bias       = 1'b0;
    wr_chg        = chg_new;
    wr_dur        = dur_now;
    wr_bias       = bp_q[cur_b];
    sw_start      = 1'b0;
    sw_start_bank = cons_bank_q;
    sw_start_mode = bte_pkg::SW_UNBIASED;
    unique case (cmd_i.op)
      bte_pkg::OP_PREP: begin
        wr_addr = slot_addr(prev_b, open_slot_q[prev_b]);
        we_dur  = close_needed;
      end
      bte_pkg::OP_OPEN: begin
        rd_addr = opening ? slot_addr(cur_b, alloc_idx) : open_addr;
        wr_addr = slot_addr(cur_b, alloc_idx);
        we_bias = opening;
      end
      bte_pkg::OP_ACC: begin
        wr_addr = open_addr;
        we_chg  = ov_q[cur_b];
        we_dur  = ov_q[cur_b];
      end
      bte_pkg::OP_CSWEEP: begin
        sw_start = 1'b1;
      end
      bte_pkg::OP_CCLR: begin
        sw_start      = 1'b1;
        sw_start_mode = bte_pkg::SW_CLEAR;
      end
      bte_pkg::OP_EST: begin
        sw_start      = 1'b1;
        sw_start_bank = cur_b;
        sw_start_mode = bte_pkg::SW_ESTIMATE;
      end
      default: begin
      end
    endcase
    // clear biased durations as the sweep returns them
    if (sw_vld_q && (sw_mode_q == bte_pkg::SW_CLEAR) && bias_rd_q) begin
      wr_addr = sw_addr_q;
      wr_dur  = 32'd0;
      we_dur  = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_chg) begin
      mem_chg[wr_addr] <= wr_chg;
    end
    if (we_dur) begin
      mem_dur[wr_addr] <= wr_dur;
    end
    if (we_bias) begin
      mem_bias[wr_addr] <= wr_bias;
    end
    chg_rd_q  <= mem_chg[rd_addr];
    dur_rd_q  <= mem_dur[rd_addr];
    bias_rd_q <= mem_bias[rd_addr];
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= bte_pkg::FULL_CHARGE_RESET;
      min_q  <= bte_pkg::MIN_WINDOW_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bte_pkg::REG_FULL_CHARGE: full_q <= cfg_data_i;
        bte_pkg::REG_MIN_WINDOW:  min_q  <= cfg_data_i[15:0];
        default: begin
        end
      endcase
    end
  end

  // bank state and item registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q      <= 1'b0;
      last_dir_q     <= bte_pkg::DIR_DISCHARGE;
      last_reading_q <= '0;
      window_q       <= '0;
      ov_q           <= '0;
      bp_q           <= '0;
      uf_q           <= '0;
      count_q[0]     <= '0;
      count_q[1]     <= '0;
      open_slot_q[0] <= '0;
      open_slot_q[1] <= '0;
      cons_bank_q    <= 1'b0;
      opened_q       <= 1'b0;
      has_q          <= 1'b0;
      reading_q      <= '0;
      dir_q          <= bte_pkg::DIR_DISCHARGE;
      prev_q         <= bte_pkg::DIR_DISCHARGE;
      now_q          <= '0;
    end else begin
      unique case (cmd_i.op)
        bte_pkg::OP_LOAD: begin
          reading_q <= in_reading_i;
          dir_q     <= (in_dir_i == bte_pkg::DIR_ALIAS) ? bte_pkg::DIR_NONE : in_dir_i;
          now_q     <= in_time_i;
          prev_q    <= last_dir_q;
          has_q     <= 1'b0;
        end
        bte_pkg::OP_FIRST: begin
          started_q      <= 1'b1;
          last_dir_q     <= dir_q;
          last_reading_q <= reading_q;
          window_q       <= now_q;
          ov_q           <= '0;
          bp_q           <= {dir_q == bte_pkg::DIR_CHARGE, dir_q == bte_pkg::DIR_DISCHARGE};
          uf_q           <= '0;
        end
        bte_pkg::OP_PREP: begin
          last_dir_q  <= dir_q;
          cons_bank_q <= prev_b;
        end
        bte_pkg::OP_NEWDIR: begin
          if (prev_q != dir_q) begin
            ov_q[cur_b] <= 1'b0;
            bp_q[cur_b] <= 1'b1;
            window_q    <= now_q;
          end
        end
        bte_pkg::OP_OPEN: begin
          opened_q <= opening;
          if (opening) begin
            if (count_q[cur_b] < CW'(SLOTS)) begin
              count_q[cur_b] <= count_q[cur_b] + CW'(1);
            end
            open_slot_q[cur_b] <= alloc_idx;
            ov_q[cur_b]        <= 1'b1;
            bp_q[cur_b]        <= 1'b0;
          end
        end
        bte_pkg::OP_ACC: begin
          if (ov_q[cur_b] && (dur_now >= {16'd0, min_q})) begin
            cons_bank_q <= cur_b;
            ov_q[cur_b] <= 1'b0;
            window_q    <= now_q;
          end
        end
        bte_pkg::OP_CCLR: begin
          uf_q[cons_bank_q] <= 1'b1;
        end
        bte_pkg::OP_EST: begin
          last_reading_q <= reading_q;
        end
        bte_pkg::OP_DIV: begin
          has_q <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // bank sweep: issue one address a cycle, accumulate its data in the next cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_active_q <= 1'b0;
      sw_vld_q    <= 1'b0;
      sw_bank_q   <= 1'b0;
      sw_mode_q   <= bte_pkg::SW_UNBIASED;
      sw_idx_q    <= '0;
      sw_addr_q   <= '0;
      tot_q       <= '0;
      tp_q        <= '0;
      tt_q        <= '0;
    end else begin
      sw_vld_q  <= sw_active_q;
      sw_addr_q <= rd_addr;
      if (sw_start) begin
        sw_active_q <= (count_q[sw_start_bank] != '0);
        sw_bank_q   <= sw_start_bank;
        sw_mode_q   <= sw_start_mode;
        sw_idx_q    <= '0;
        tot_q       <= '0;
        tp_q        <= '0;
        tt_q        <= '0;
      end else begin
        if (sw_active_q) begin
          if ((sw_idx_q + CW'(1)) == count_q[sw_bank_q]) begin
            sw_active_q <= 1'b0;
          end else begin
            sw_idx_q <= sw_idx_q + CW'(1);
          end
        end
        if (sw_vld_q) begin
          case (sw_mode_q)
            bte_pkg::SW_UNBIASED: begin
              if (!bias_rd_q) begin
                tot_q <= tot_q + TW'(dur_rd_q);
              end
            end
            bte_pkg::SW_ESTIMATE: begin
              if (dur_rd_q != 32'd0) begin
                tp_q <= tp_q + TW'(abs_chg);
                tt_q <= tt_q + TW'(dur_rd_q);
              end
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  bte_muldiv #(
    .TW(TW)
  ) u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.op == bte_pkg::OP_DIV),
    .mag_i   (rem[24] ? 24'(25'd0 - rem) : rem[23:0]),
    .neg_i   (rem[24]),
    .tt_i    (tt_q),
    .tp_i    (tp_q),
    .busy_o  (div_busy),
    .result_o(div_res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q   <= 1'b0;
      out_has_q     <= 1'b0;
      out_seconds_q <= '0;
    end else if (cmd_i.op == bte_pkg::OP_RES) begin
      out_valid_q   <= 1'b1;
      out_has_q     <= has_q;
      out_seconds_q <= has_q ? div_res : bte_pkg::NO_ESTIMATE;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_comb begin
    status_o.started      = started_q;
    status_o.close_needed = close_needed;
    status_o.dir_none     = (dir_q == bte_pkg::DIR_NONE);
    status_o.reading_diff = (reading_q != last_reading_q);
    status_o.open_now     = ov_q[cur_b];
    status_o.dur_ge_min   = (dur_now >= {16'd0, min_q});
    status_o.cons_filled  = uf_q[cons_bank_q];
    status_o.tot_ge_min   = (tot_q >= TW'(min_q));
    status_o.count_nz     = (count_q[cur_b] != '0);
    status_o.tp_nz        = (tp_q != '0);
    status_o.sweep_busy   = sw_active_q | sw_vld_q;
    status_o.div_busy     = div_busy;
    status_o.out_free     = !out_valid_q || out_ready_i;
  end

  assign out_valid_o   = out_valid_q;
  assign out_seconds_o = out_seconds_q;
  assign out_has_o     = out_has_q;

endmodule

@@ rtl/bte_ctrl.sv @@
// ----------------------------------------------------------------------------
// bte_ctrl: sequencer of the estimator
// Steps one item through load, slot close, slot update, consolidation,
// estimate sweep, division and result hand-off.
// ----------------------------------------------------------------------------
module bte_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  bte_pkg::status_t status_i,
  output bte_pkg::cmd_t    cmd_o
);

  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_CHK  = 12'b0000_0000_0010,
    S_CONS = 12'b0000_0000_0100,
    S_CSUM = 12'b0000_0000_1000,
    S_CCLR = 12'b0000_0001_0000,
    S_POST = 12'b0000_0010_0000,
    S_OPEN = 12'b0000_0100_0000,
    S_ACC  = 12'b0000_1000_0000,
    S_EST  = 12'b0001_0000_0000,
    S_ESUM = 12'b0010_0000_0000,
    S_DIV  = 12'b0100_0000_0000,
    S_RES  = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   ret_acc_q, ret_acc_d;
  state_e ret_state;

  assign ret_state = ret_acc_q ? S_EST : S_POST;

  always_comb begin
    state_d    = state_q;
    ret_acc_d  = ret_acc_q;
    cmd_o.op   = bte_pkg::OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = bte_pkg::OP_LOAD;
          state_d  = S_CHK;
        end
      end
      S_CHK: begin
        if (!status_i.started) begin
          cmd_o.op = bte_pkg::OP_FIRST;
          state_d  = S_RES;
        end else begin
          cmd_o.op = bte_pkg::OP_PREP;
          if (status_i.close_needed) begin
            ret_acc_d = 1'b0;
            state_d   = S_CONS;
          end else begin
            state_d = S_POST;
          end
        end
      end
      S_CONS: begin
        if (status_i.cons_filled) begin
          state_d = ret_state;
        end else begin
          cmd_o.op = bte_pkg::OP_CSWEEP;
          state_d  = S_CSUM;
        end
      end
      S_CSUM: begin
        if (!status_i.sweep_busy) begin
          if (status_i.tot_ge_min) begin
            cmd_o.op = bte_pkg::OP_CCLR;
            state_d  = S_CCLR;
          end else begin
            state_d = ret_state;
          end
        end
      end
      S_CCLR: begin
        if (!status_i.sweep_busy) begin
          state_d = ret_state;
        end
      end
      S_POST: begin
        if (status_i.dir_none) begin
          state_d = S_RES;
        end else begin
          cmd_o.op = bte_pkg::OP_NEWDIR;
          state_d  = status_i.reading_diff ? S_OPEN : S_EST;
        end
      end
      S_OPEN: begin
        cmd_o.op = bte_pkg::OP_OPEN;
        state_d  = S_ACC;
      end
      S_ACC: begin
        cmd_o.op = bte_pkg::OP_ACC;
        if (status_i.open_now && status_i.dur_ge_min) begin
          ret_acc_d = 1'b1;
          state_d   = S_CONS;
        end else begin
          state_d = S_EST;
        end
      end
      S_EST: begin
        cmd_o.op = bte_pkg::OP_EST;
        state_d  = status_i.count_nz ? S_ESUM : S_RES;
      end
      S_ESUM: begin
        if (!status_i.sweep_busy) begin
          if (status_i.tp_nz) begin
            cmd_o.op = bte_pkg::OP_DIV;
            state_d  = S_DIV;
          end else begin
            state_d = S_RES;
          end
        end
      end
      S_DIV: begin
        if (!status_i.div_busy) begin
          state_d = S_RES;
        end
      end
      S_RES: begin
        if (status_i.out_free) begin
          cmd_o.op = bte_pkg::OP_RES;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ret_acc_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ret_acc_q <= ret_acc_d;
    end
  end

endmodule

@@ rtl/battery_time_left_estimator.sv @@
// ----------------------------------------------------------------------------
// battery_time_left_estimator: seconds-to-empty / seconds-to-full estimator
// Keeps a bank of charge-change slots per direction, reusing slot 0 once full,
// and divides remaining charge times elapsed time by the absolute charge change.
//
//   channel   dir  fields (lowest bit first)
//   s_axis    in   tdata: charge_reading[23:0], direction[25:24],
//                         time_now[57:26], zero pad[63:58]
//   m_axis    out  tdata: seconds_left[31:0]; tuser: has_estimate
//   cfg       in   cfg_idx_i 0 full_charge_reading, 1 min_window_seconds
//
// Flow: one transaction at a time. An item sweeps a slot bank up to five
// times (two consolidations, two clears of biased slots and the estimate
// sum) and runs the serial multiply/divide unit when an estimate is formed.
// Reset: rst_ni clears all control and bank state at once; the slot memory
// is not cleared, as only slots already written are ever read.
// Stalls: a held result in the output register does not block the next
// input transaction; only the hand-off of the following result waits.
// ----------------------------------------------------------------------------
module battery_time_left_estimator #(
  parameter int unsigned SLOTS_PER_DIRECTION = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input item stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // charge_reading, direction, time_now, pad
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // seconds_left
  output logic        m_axis_tuser,  // has_estimate
  // configuration writes
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [23:0] cfg_data_i
);

  bte_pkg::cmd_t    cmd;
  bte_pkg::status_t status;

  // sequence each item; only the idle state takes a transaction
  bte_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  // slot store, sums, divider and the result register
  bte_datapath #(
    .SLOTS(SLOTS_PER_DIRECTION)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .in_reading_i (s_axis_tdata[23:0]),
    .in_dir_i     (s_axis_tdata[25:24]),
    .in_time_i    (s_axis_tdata[57:26]),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_seconds_o(m_axis_tdata),
    .out_has_o    (m_axis_tuser)
  );

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench of the battery time-left estimator
// Drives readings through the input stream, predicts every estimate with a
// local model of the slot banks and compares each result transaction with
// the oldest prediction. A directed table comes first, then random runs of
// charge, discharge and no direction under several register settings and idling mixes.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int NSLOT = 16;
  localparam int LIMIT = 4000000;
  localparam int HOLD_CYCLES = 3000;

  typedef struct packed {
    logic [31:0] secs;
    logic        valid_est;
  } estimate_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [23:0] cfg_data_i = '0;

  battery_time_left_estimator dut (.*);

  always #6 clk_i = ~clk_i;

  // predictor state
  logic [23:0] full_rd;
  logic [15:0] min_win;
  logic        started;
  logic [1:0]  last_dir;
  logic [23:0] last_rd;
  logic [31:0] win_start;
  logic        open_v[2];
  int          open_ix[2];
  int          used[2];
  logic        bias_pend[2];
  logic        ub_filled[2];
  logic [31:0] s_chg[2][NSLOT];
  logic [31:0] s_dur[2][NSLOT];
  logic        s_bias[2][NSLOT];

  estimate_t   pending_est[$];
  int          errors = 0;
  int          cycles = 0;
  int          send_idle = 21;
  int          recv_idle = 60;
  int          hold_off = 0;
  int          hold_asks = 0;
  int          hold_seen = 0;
  logic [23:0] gen_rd;
  logic [31:0] gen_t;

  // merge biased slots away once enough unbiased time has gathered
  function automatic void fold_bank(int d);
    logic [63:0] tot;
    tot = 0;
    if (ub_filled[d]) return;
    for (int i = 0; i < used[d]; i++)
      if (!s_bias[d][i]) tot += s_dur[d][i];
    if (tot >= min_win) begin
      ub_filled[d] = 1'b1;
      for (int i = 0; i < used[d]; i++)
        if (s_bias[d][i]) s_dur[d][i] = 0;
    end
  endfunction

  function automatic estimate_t predict_estimate(logic [23:0] rd, logic [1:0] dir_in,
                                                 logic [31:0] now);
    estimate_t   r;
    logic [1:0]  dir, prev;
    logic [63:0] tp, tt;
    logic signed [63:0] rem, q;
    logic [31:0] c, dur, mag;
    logic        ok;
    int          ix;
    r.secs = bte_pkg::NO_ESTIMATE;
    r.valid_est = 1'b0;
    dir = (dir_in == bte_pkg::DIR_ALIAS) ? bte_pkg::DIR_NONE : dir_in;
    if (!started) begin
      started = 1'b1;
      last_dir = dir;
      last_rd = rd;
      win_start = now;
      open_v[0] = 0; open_v[1] = 0;
      bias_pend[0] = (dir == bte_pkg::DIR_DISCHARGE);
      bias_pend[1] = (dir == bte_pkg::DIR_CHARGE);
      ub_filled[0] = 0; ub_filled[1] = 0;
      return r;
    end
    prev = last_dir;
    last_dir = dir;
    if (prev != dir && prev < 2 && open_v[prev]) begin
      s_dur[prev][open_ix[prev]] = now - win_start;
      fold_bank(prev);
    end
    if (dir == bte_pkg::DIR_NONE) return r;
    if (prev != dir) begin
      open_v[dir] = 0;
      bias_pend[dir] = 1;
      win_start = now;
    end
    if (last_rd != rd) begin
      ok = open_v[dir];
      if (!ok && !(bias_pend[dir] && ub_filled[dir])) begin
        if (used[dir] < NSLOT) begin
          ix = used[dir];
          used[dir]++;
        end else begin
          ix = 0;
        end
        s_chg[dir][ix] = 0;
        s_bias[dir][ix] = bias_pend[dir];
        s_dur[dir][ix] = 0;
        open_ix[dir] = ix;
        open_v[dir] = 1;
        bias_pend[dir] = 0;
        ok = 1;
      end
      if (ok) begin
        dur = now - win_start;
        s_chg[dir][open_ix[dir]] += 32'(rd) - 32'(last_rd);
        s_dur[dir][open_ix[dir]] = dur;
        if (dur >= min_win) begin
          fold_bank(dir);
          open_v[dir] = 0;
          win_start = now;
        end
      end
    end
    last_rd = rd;
    if (used[dir] > 0) begin
      tp = 0; tt = 0;
      for (int i = 0; i < used[dir]; i++) begin
        c = s_chg[dir][i];
        if (s_dur[dir][i] != 0) begin
          mag = c[31] ? (32'd0 - c) : c;
          tp += 64'(mag);
          tt += s_dur[dir][i];
        end
      end
      if (tp != 0) begin
        rem = dir[0] ? $signed(64'(full_rd)) - $signed(64'(rd)) : $signed(64'(rd));
        q = (rem * $signed(tt)) / $signed(tp);
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        r.secs = q[31:0];
        r.valid_est = 1'b1;
      end
    end
    return r;
  endfunction

  // offer one reading; drop valid only while idling, hold it until the
  // transaction completes
  task automatic send_reading(logic [23:0] rd, logic [1:0] dir, logic [31:0] now);
    if ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
      while ($urandom_range(99) < send_idle) @(negedge clk_i);
    end
    s_axis_tdata <= {6'd0, now, dir, rd};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_est.push_back(predict_estimate(rd, dir, now));
    @(negedge clk_i);
  endtask

  // end a burst of input transactions
  task automatic stop_input();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [23:0] val);
    stop_input();
    while (pending_est.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == bte_pkg::REG_FULL_CHARGE) full_rd = val;
    else min_win = val[15:0];
  endtask

  // receiver side: random ready, with a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_seen != hold_asks) begin
      hold_seen <= hold_asks;
      hold_off <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk_i) begin
    estimate_t exp_e;
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("battery_time_left_estimator test failed");
      $finish;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_est.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h/%b", m_axis_tdata, m_axis_tuser);
      end else begin
        exp_e = pending_est.pop_front();
        if (exp_e.secs !== m_axis_tdata || exp_e.valid_est !== m_axis_tuser) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected %h/%b got %h/%b", exp_e.secs, exp_e.valid_est,
                     m_axis_tdata, m_axis_tuser);
        end
      end
    end
  end

  // one random run: mostly steady walks in one direction, some noise
  task automatic random_run(int n);
    logic [1:0] dir;
    int step;
    dir = 2'($urandom_range(2));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 8) dir = 2'($urandom_range(3));
      step = $urandom_range(2000);
      if ($urandom_range(99) < 10) step = 0; // unchanged reading
      if (dir == bte_pkg::DIR_DISCHARGE) gen_rd = gen_rd - 24'(step);
      else if (dir == bte_pkg::DIR_CHARGE) gen_rd = gen_rd + 24'(step);
      if ($urandom_range(99) < 3) gen_rd = 24'($urandom);
      gen_t = gen_t + $urandom_range(($urandom_range(9) == 0) ? 200 : 12);
      if ($urandom_range(199) == 0) gen_t = $urandom;
      send_reading(gen_rd, dir, gen_t);
    end
  endtask

  typedef struct {
    logic [23:0] rd;
    logic [1:0]  dir;
    logic [31:0] now;
    logic        typed;   // expected value typed in
    estimate_t   want;
  } stim_row_t;

  stim_row_t dir_tab[$];

  initial begin
    full_rd = bte_pkg::FULL_CHARGE_RESET;
    min_win = bte_pkg::MIN_WINDOW_RESET;
    started = 0; last_dir = 0; last_rd = 0; win_start = 0;
    for (int d = 0; d < 2; d++) begin
      open_v[d] = 0; open_ix[d] = 0; used[d] = 0; bias_pend[d] = 0; ub_filled[d] = 0;
    end
    // first item, then extremes, direction neither and its alias, charging up to full, discharging
    dir_tab = '{
      '{24'hFFFFFF, bte_pkg::DIR_DISCHARGE, 32'hFFFFFFF0, 1, '{bte_pkg::NO_ESTIMATE, 1'b0}},
      '{24'hFFFF00, bte_pkg::DIR_DISCHARGE, 32'h00000020, 0, '{0, 0}},
      '{24'h000000, bte_pkg::DIR_DISCHARGE, 32'h00000080, 0, '{0, 0}},
      '{24'h000000, bte_pkg::DIR_NONE,      32'h00000090, 1, '{bte_pkg::NO_ESTIMATE, 1'b0}},
      '{24'h123456, bte_pkg::DIR_ALIAS,     32'h000000A0, 1, '{bte_pkg::NO_ESTIMATE, 1'b0}},
      '{24'h000000, bte_pkg::DIR_CHARGE,    32'h000000B0, 0, '{0, 0}},
      '{24'h000010, bte_pkg::DIR_CHARGE,    32'h000000C0, 0, '{0, 0}},
      '{24'h800000, bte_pkg::DIR_CHARGE,    32'h00000200, 0, '{0, 0}},
      '{24'hFFFFFF, bte_pkg::DIR_CHARGE,    32'hFFFFFFFF, 0, '{0, 0}},
      '{24'hFFFFFF, bte_pkg::DIR_CHARGE,    32'h00000010, 0, '{0, 0}},
      '{24'h7FFFFF, bte_pkg::DIR_DISCHARGE, 32'h00000100, 0, '{0, 0}},
      '{24'h7FFF00, bte_pkg::DIR_DISCHARGE, 32'h00000200, 0, '{0, 0}},
      '{24'h7FFF00, bte_pkg::DIR_DISCHARGE, 32'h00000210, 0, '{0, 0}}
    };
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);
    foreach (dir_tab[i]) begin
      send_reading(dir_tab[i].rd, dir_tab[i].dir, dir_tab[i].now);
      if (dir_tab[i].typed) pending_est[$] = dir_tab[i].want;
    end
    gen_rd = 24'h800000;
    gen_t = 32'h1000;
    random_run(300);
    // lower the full level so charging readings run past it
    write_reg(bte_pkg::REG_FULL_CHARGE, 24'h000400);
    write_reg(bte_pkg::REG_MIN_WINDOW, 24'd1);
    random_run(250);
    // long hold-off on the result side while items keep coming
    hold_asks++;
    random_run(60);
    send_idle = 60;
    recv_idle = 21;
    write_reg(bte_pkg::REG_MIN_WINDOW, 24'd65535);
    write_reg(bte_pkg::REG_FULL_CHARGE, 24'hFFFFFF);
    random_run(300);
    send_idle = 0;
    recv_idle = 0;
    write_reg(bte_pkg::REG_MIN_WINDOW, 24'd30);
    write_reg(bte_pkg::REG_FULL_CHARGE, 24'h000000);
    random_run(250);
    write_reg(bte_pkg::REG_FULL_CHARGE, 24'h9ABCDE);
    write_reg(bte_pkg::REG_MIN_WINDOW, 24'd60);
    random_run(250);
    stop_input();
    while (pending_est.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    if (errors == 0) begin
      $display("battery_time_left_estimator test passed");
    end else begin
      $display("battery_time_left_estimator test failed");
    end
    $finish;
  end
endmodule
